// ----- hw/rtl/ffba_pkg.sv -----
// Shared types and constants for the first-fit block allocator.
// No dependencies; used by ffba_engine and the top level.
package ffba_pkg;

  localparam int MEMORY_UNITS_DEF  = 1024;
  localparam int OWNER_ID_BITS_DEF = 10;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // configuration register index (byte address bit 2)
  localparam logic REG_UNITS_IN_USE = 1'b0;
  localparam logic [10:0] UNITS_IN_USE_RESET = 11'd1024;

  typedef struct packed {
    logic        kind;
    logic [10:0] size;
    logic [9:0]  owner_id;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [9:0]  start_index;
    logic [10:0] freed_count;
  } res_t;

endpackage

// ----- hw/rtl/ffba_owner_ram.sv -----
// Owner tag store: one write port, one read port, registered read data.
// No package dependencies.
module ffba_owner_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/ffba_engine.sv -----
// Allocation/free sequencer: walks the owner store one unit per cycle.
// Depends on ffba_pkg and ffba_owner_ram.
module ffba_engine #(
  parameter int MEMORY_UNITS  = ffba_pkg::MEMORY_UNITS_DEF,
  parameter int OWNER_ID_BITS = ffba_pkg::OWNER_ID_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  ffba_pkg::req_t  req,
  input  logic            req_valid,
  output logic            req_ready,
  input  logic [10:0]     units_in_use,
  output ffba_pkg::res_t  res,
  output logic            res_valid,
  input  logic            res_take
);

  localparam int AW = (MEMORY_UNITS > 1) ? $clog2(MEMORY_UNITS) : 1;
  localparam int CW = $clog2(MEMORY_UNITS + 1);
  localparam int LW = (CW > 11) ? CW : 11;
  localparam int TW = OWNER_ID_BITS;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FILL  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic          op_free;
  logic [TW-1:0] tag;
  logic [CW-1:0] size_c, scan_end, rd_addr, run, freed;
  logic [AW-1:0] chk_addr, clr_addr, fill_addr, fill_last;
  logic          rd_pend;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [TW-1:0] mem_wdata, mem_rdata;

  logic [TW-1:0] req_tag;
  logic [CW-1:0] limit, run_inc, start_w;
  logic          alloc_valid, accept, issue, hit_free, hit_tag, found, scan_over;

  ffba_owner_ram #(.DEPTH(MEMORY_UNITS), .AW(AW), .DW(TW)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    req_tag = TW'(req.owner_id);
    if (LW'(units_in_use) > LW'(MEMORY_UNITS)) begin
      limit = CW'(MEMORY_UNITS);
    end else begin
      limit = CW'(units_in_use);
    end
    alloc_valid = (req.size != '0) && (req_tag != '0) && (LW'(req.size) <= LW'(limit));
    accept    = (state == ST_IDLE) && req_valid;
    issue     = (state == ST_SCAN) && (rd_addr < scan_end);
    hit_free  = rd_pend && (mem_rdata == '0);
    hit_tag   = rd_pend && (mem_rdata == tag);
    run_inc   = run + CW'(1);
    found     = (state == ST_SCAN) && !op_free && hit_free && (run_inc == size_c);
    scan_over = (state == ST_SCAN) && !issue && !rd_pend;
    start_w   = CW'(chk_addr) + CW'(1) - size_c;
  end

  // store access
  always_comb begin
    mem_re    = issue;
    mem_raddr = rd_addr[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = chk_addr;
    mem_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      ST_SCAN: begin
        mem_we = op_free && hit_tag;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_addr;
        mem_wdata = tag;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(MEMORY_UNITS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          if (req.kind == ffba_pkg::KIND_FREE) begin
            state_next = (req_tag != '0) ? ST_SCAN : ST_DONE;
          end else begin
            state_next = alloc_valid ? ST_SCAN : ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (found) begin
          state_next = ST_FILL;
        end else if (scan_over) begin
          state_next = ST_DONE;
        end
      end
      ST_FILL: begin
        if (fill_addr == fill_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue && !found;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_free  <= req.kind;
      tag      <= req_tag;
      size_c   <= CW'(req.size);
      scan_end <= (req.kind == ffba_pkg::KIND_FREE) ? CW'(MEMORY_UNITS) : limit;
      rd_addr  <= '0;
      run      <= '0;
      freed    <= '0;
      // immediate answer; replaced when a walk runs
      res.ok          <= req.kind;
      res.start_index <= '0;
      res.freed_count <= '0;
    end
    if (issue) begin
      rd_addr  <= rd_addr + CW'(1);
      chk_addr <= rd_addr[AW-1:0];
    end
    if ((state == ST_SCAN) && rd_pend) begin
      if (op_free) begin
        if (hit_tag) freed <= freed + CW'(1);
      end else begin
        run <= hit_free ? run_inc : '0;
      end
    end
    if (found) begin
      fill_addr       <= start_w[AW-1:0];
      fill_last       <= chk_addr;
      res.ok          <= 1'b1;
      res.start_index <= 10'(start_w);
      res.freed_count <= '0;
    end else if (scan_over) begin
      res.ok          <= op_free;
      res.start_index <= '0;
      res.freed_count <= 11'(freed);
    end
    if (state == ST_FILL) fill_addr <= fill_addr + AW'(1);
  end

  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

`ifndef NO_ASSERTIONS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
    else $error("read and write hit the same unit");
  a_fill_no_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> !mem_re)
    else $error("read issued while filling");
  a_alloc_no_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !op_free) |-> (res.freed_count == '0))
    else $error("allocate result carries a freed count");
  a_free_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && op_free) |-> (res.ok && res.start_index == '0))
    else $error("free result malformed");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != ST_IDLE))
    else $error("accepted request left engine idle");
`endif

endmodule

// ----- hw/rtl/first_fit_block_allocator_top.sv -----
// Top level of the first-fit block allocator: stream ports, APB register, result slot.
// Depends on ffba_pkg and ffba_engine.
//
// Usage
//   Requests enter on the s_* stream: tuser is the kind (0 allocate, 1 free),
//   tdata carries size and owner_id. Each request gives exactly one result on
//   the m_* stream: tuser is ok, tdata carries start_index and freed_count.
//   Allocate finds the lowest run of 'size' free units below units_in_use and
//   tags it; free clears every unit carrying owner_id and reports the count.
//   Write units_in_use over APB (byte address 0) only while idle; not enforced here.
// Timing
//   One request at a time; the owner store is walked one unit per cycle
//   through its single read port. A free walks all MEMORY_UNITS units; an
//   allocate walks to the end of the lowest fitting run, then tags the run,
//   or walks min(units_in_use, MEMORY_UNITS) units when no run fits. Rejected
//   requests (size 0, owner 0, size above the unit count) and frees of owner 0
//   answer without a walk.
// Reset and stall
//   After rst the store is swept to zero, every unit in turn, with s_tready low.
//   A finished result waits in the output register; the next request is still
//   taken, and its result holds in the engine until m_tready frees the slot.
module first_fit_block_allocator_top #(
  parameter int MEMORY_UNITS  = ffba_pkg::MEMORY_UNITS_DEF,
  parameter int OWNER_ID_BITS = ffba_pkg::OWNER_ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [10:0] size, [20:11] owner_id, [23:21] zero
  input  logic        s_tuser,   // [0] kind
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [9:0] start_index, [20:10] freed_count, [23:21] zero
  output logic        m_tuser,   // [0] ok
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ffba_pkg::req_t req;
  ffba_pkg::res_t res;
  logic           res_valid, res_take;
  logic [10:0]    units_in_use;

  // register index is byte address bit 2; byte lanes within the word ignored
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ffba_pkg::REG_UNITS_IN_USE) ? {21'd0, units_in_use} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      units_in_use <= ffba_pkg::UNITS_IN_USE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == ffba_pkg::REG_UNITS_IN_USE)) begin
      units_in_use <= pwdata[10:0];
    end
  end

  assign req.kind     = s_tuser;
  assign req.size     = s_tdata[10:0];
  assign req.owner_id = s_tdata[20:11];

  ffba_engine #(
    .MEMORY_UNITS (MEMORY_UNITS),
    .OWNER_ID_BITS(OWNER_ID_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .req_valid   (s_tvalid),
    .req_ready   (s_tready),
    .units_in_use(units_in_use),
    .res         (res),
    .res_valid   (res_valid),
    .res_take    (res_take)
  );

  // output slot: loads when empty or being drained this cycle
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tuser <= res.ok;
      m_tdata <= {3'd0, res.freed_count, res.start_index};
    end
  end

endmodule
